// ===== sv/dcutb_pkg.sv =====
// Package for the down-counter microsecond timebase.
// Holds widths, the register index and the controller/datapath interface types.
// No dependencies.
package dcutb_pkg;

    localparam int COUNT_W     = 32;
    localparam int TICKS_W     = 10;
    localparam int USEC_W      = 64;
    localparam int DIV_STEPS   = COUNT_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(100);

    // Register index, taken from the word address bit of paddr
    localparam logic REG_TICKS_PER_USEC = 1'b0;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // take the new reading and set up the divider
        logic step;    // run one restoring-division iteration
        logic commit;  // update total and reference, load the output register
    } dcutb_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic first;     // no reference latched yet
        logic div_zero;  // ticks per microsecond is zero
    } dcutb_sts_t;

endpackage

// ===== sv/down_counter_microsecond_timebase_unit.sv =====
// Top level of the down-counter microsecond timebase.
// Holds the APB register and joins dcutb_ctrl with dcutb_dp.
// Depends on dcutb_pkg, dcutb_ctrl, dcutb_dp.
//
// Usage:
//   Input channel (in_valid, in_stall, counter_value) takes one reading of a
//   free-running 32-bit down-counter per transaction. Output channel
//   (out_valid, out_stall, time_usecs, advanced) returns one result per
//   reading: the 64-bit microsecond total and whether it advanced.
//   The first reading after reset latches the reference and returns zero.
//   Sequence: a normal reading runs 32 divide steps after the accepting edge,
//   then the commit; for the first reading or ticks_per_usec zero the divide
//   is skipped and the controller goes straight to the commit. The next
//   transaction is accepted only once the previous one has committed; the
//   restoring divider yields one quotient bit per cycle.
//   A finished result waits in the output register; a new reading can be
//   accepted and divided meanwhile, and its commit waits while out_stall is
//   high. At reset the total, reference and started flag clear and
//   ticks_per_usec returns to 100. The APB register ticks_per_usec sits at
//   byte address 0; write it only while the block is idle.
module down_counter_microsecond_timebase_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dcutb_pkg::COUNT_W-1:0]     counter_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dcutb_pkg::USEC_W-1:0]      time_usecs,
    output logic                              advanced,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dcutb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dcutb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dcutb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import dcutb_pkg::*;

    logic [TICKS_W-1:0] ticks_reg;
    logic               reg_sel;
    dcutb_cmd_t         cmd;
    dcutb_sts_t         sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_TICKS_PER_USEC);

    // Write the ticks register on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ticks_reg <= TICKS_RESET;
        else if (psel && penable && pwrite && pready && reg_sel)
            ticks_reg <= pwdata[TICKS_W-1:0];
    end

    // Read back the register, zero elsewhere
    assign prdata = reg_sel ? APB_DATA_W'(ticks_reg) : '0;

    dcutb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    dcutb_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .counter_value  (counter_value),
        .ticks_per_usec (ticks_reg),
        .time_usecs     (time_usecs),
        .advanced       (advanced)
    );

endmodule

// ===== sv/dcutb_ctrl.sv =====
// Controller for the down-counter microsecond timebase.
// Sequences accept, 32 divide steps or none, then commit; owns output valid.
// Depends on dcutb_pkg.
module dcutb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  dcutb_pkg::dcutb_sts_t sts,
    output dcutb_pkg::dcutb_cmd_t cmd
);
    import dcutb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_FINISH
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                out_valid_reg;
    logic                accept;
    logic                out_free;

    // Accept only while idle; the output register keeps the last result meanwhile
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // Decode commands from state
    always_comb
    begin
        cmd.load   = accept;
        cmd.step   = (state_reg == S_DIVIDE);
        cmd.commit = (state_reg == S_FINISH) && out_free;
    end

    // Hold state, step count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the result once taken; a commit sets it again
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    if (accept)
                    begin
                        if (sts.first || sts.div_zero)
                            state_reg <= S_FINISH;
                        else
                            state_reg <= S_DIVIDE;
                    end
                end
                S_DIVIDE:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                        state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // An accepted transaction blocks the input until its result is committed
    a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // A commit always presents a result next cycle
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit without output valid");

    // A commit never overwrites a result still waiting to be taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || !out_stall))
        else $error("pending result overwritten");

    // Load, step and commit never overlap
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !((cmd.load && cmd.step) || (cmd.load && cmd.commit) || (cmd.step && cmd.commit)))
        else $error("overlapping datapath commands");

endmodule

// ===== sv/dcutb_dp.sv =====
// Datapath for the down-counter microsecond timebase.
// Holds reference, total, a bit-serial restoring divider and the output register.
// Depends on dcutb_pkg.
module dcutb_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dcutb_pkg::dcutb_cmd_t       cmd,
    output dcutb_pkg::dcutb_sts_t       sts,
    input  logic [dcutb_pkg::COUNT_W-1:0] counter_value,
    input  logic [dcutb_pkg::TICKS_W-1:0] ticks_per_usec,
    output logic [dcutb_pkg::USEC_W-1:0]  time_usecs,
    output logic                        advanced
);
    import dcutb_pkg::*;

    logic                 started_reg;
    logic [COUNT_W-1:0]   ref_reg;
    logic [USEC_W-1:0]    total_reg;
    logic [COUNT_W-1:0]   reading_reg;
    logic [COUNT_W-1:0]   dividend_reg;
    logic [COUNT_W-1:0]   quot_reg;
    logic [TICKS_W-1:0]   rem_reg;
    logic [TICKS_W-1:0]   divisor_reg;
    logic [USEC_W-1:0]    time_reg;
    logic                 adv_reg;

    logic [TICKS_W:0]     rem_shift;
    logic                 fits;
    logic [TICKS_W:0]     rem_diff;
    logic [USEC_W-1:0]    total_next;
    logic                 adv_next;

    assign sts.first    = !started_reg;
    assign sts.div_zero = (ticks_per_usec == '0);

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, dividend_reg[COUNT_W-1]};
    assign fits      = (rem_shift >= {1'b0, divisor_reg});
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    // Advance the total only on a nonzero quotient after the first reading
    assign adv_next   = started_reg && (quot_reg != '0);
    assign total_next = adv_next ? (total_reg + USEC_W'(quot_reg)) : total_reg;

    // Hold timebase state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            ref_reg     <= '0;
            total_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            started_reg <= 1'b1;
            total_reg   <= total_next;
            if (!started_reg || adv_next)
                ref_reg <= reading_reg;
        end
    end

    // Divider and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            reading_reg  <= counter_value;
            dividend_reg <= ref_reg - counter_value;
            divisor_reg  <= ticks_per_usec;
            rem_reg      <= '0;
            quot_reg     <= '0;
        end
        else if (cmd.step)
        begin
            dividend_reg <= {dividend_reg[COUNT_W-2:0], 1'b0};
            rem_reg      <= fits ? rem_diff[TICKS_W-1:0] : rem_shift[TICKS_W-1:0];
            quot_reg     <= {quot_reg[COUNT_W-2:0], fits};
        end

        if (cmd.commit)
        begin
            time_reg <= total_next;
            adv_reg  <= adv_next;
        end
    end

    assign time_usecs = time_reg;
    assign advanced   = adv_reg;

    // The first commit after reset never reports an advance
    a_first_no_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !started_reg) |=> !advanced)
        else $error("advance reported on first reading");

    // A reported advance always grows the total
    a_adv_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && adv_next) |=> (total_reg != $past(total_reg)))
        else $error("advance without total change");

    // The reference moves only on a commit
    a_ref_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(ref_reg))
        else $error("reference moved outside commit");

endmodule

// ===== verif/usec_timebase_checker.sv =====
// Scoreboard for the down-counter microsecond timebase.
// Follows the tick register through APB writes, predicts each result and compares.
// Depends on dcutb_pkg.
module usec_timebase_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [dcutb_pkg::COUNT_W-1:0]     counter_value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [dcutb_pkg::USEC_W-1:0]      time_usecs,
    input  logic                              advanced,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [dcutb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dcutb_pkg::APB_DATA_W-1:0]  pwdata,
    output int                                pending,
    output int                                mismatches,
    output int                                results_checked
);
    import dcutb_pkg::*;

    typedef struct packed {
        logic [USEC_W-1:0] usecs;
        logic              adv;
    } usec_result_t;

    logic [TICKS_W-1:0] ticks_shadow;
    logic               ref_latched;
    logic [COUNT_W-1:0] ref_reading;
    logic [USEC_W-1:0]  usec_total;
    usec_result_t       results_due[$];
    int                 fail_count;
    int                 match_count;

    assign mismatches      = fail_count;
    assign results_checked = match_count;

    // Advance the predicted timebase by one reading and return its result
    function automatic usec_result_t step_timebase(input logic [COUNT_W-1:0] reading);
        logic [COUNT_W-1:0] elapsed;
        logic [COUNT_W-1:0] whole_usecs;
        usec_result_t       res;
        res.adv = 1'b0;
        if (!ref_latched) begin
            ref_reading = reading;
            ref_latched = 1'b1;
        end
        else begin
            elapsed     = ref_reading - reading;
            whole_usecs = '0;
            if (ticks_shadow != '0)
                whole_usecs = elapsed / COUNT_W'(ticks_shadow);
            if (whole_usecs != '0) begin
                usec_total  = usec_total + USEC_W'(whole_usecs);
                ref_reading = reading;
                res.adv     = 1'b1;
            end
        end
        res.usecs = usec_total;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        usec_result_t due;
        if (!rst_n) begin
            ticks_shadow = TICKS_RESET;
            ref_latched  = 1'b0;
            ref_reading  = '0;
            usec_total   = '0;
            results_due.delete();
            fail_count   = 0;
            match_count  = 0;
            pending     <= 0;
        end
        else begin
            // Track register writes; only the first word address is mapped
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_TICKS_PER_USEC)
                    ticks_shadow = pwdata[TICKS_W-1:0];
            end

            // Compare each result transaction with the oldest prediction
            if (out_valid && !out_stall) begin
                if (results_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual usecs %h advanced %b",
                             $realtime, time_usecs, advanced);
                end
                else begin
                    due = results_due.pop_front();
                    match_count++;
                    if (time_usecs !== due.usecs) begin
                        fail_count++;
                        $display("%0t: time_usecs mismatch, expected %h actual %h",
                                 $realtime, due.usecs, time_usecs);
                    end
                    if (advanced !== due.adv) begin
                        fail_count++;
                        $display("%0t: advanced mismatch, expected %b actual %b",
                                 $realtime, due.adv, advanced);
                    end
                end
            end

            // Predict the result of each accepted reading
            if (in_valid && !in_stall)
                results_due.push_back(step_timebase(counter_value));

            pending <= results_due.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the down-counter microsecond timebase.
// Drives readings, the result stall and APB writes; usec_timebase_checker checks.
// Depends on dcutb_pkg, down_counter_microsecond_timebase_unit, usec_timebase_checker.
module tb;
    import dcutb_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 3;
    localparam int SEG_ITEMS     = 95;
    localparam int NUM_SEGS      = 12;
    localparam int SEGS_PER_PASS = 4;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_TICKS  = -1;

    localparam logic [APB_ADDR_W-1:0] ADDR_TICKS_PER_USEC =
        APB_ADDR_W'({REG_TICKS_PER_USEC, 2'b00});
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED =
        APB_ADDR_W'({~REG_TICKS_PER_USEC, 2'b00});

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [COUNT_W-1:0]    counter_value = '0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [USEC_W-1:0]     time_usecs;
    logic                  advanced;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    pending;
    int                    mismatches;
    int                    results_checked;

    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    hold_left     = 0;
    int                    readings_sent = 0;
    int                    tick_writes   = 0;
    int unsigned           cycle_count   = 0;
    logic [TICKS_W-1:0]    ticks_now     = TICKS_RESET;
    logic [COUNT_W-1:0]    cursor        = '0;

    down_counter_microsecond_timebase_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .counter_value (counter_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .time_usecs    (time_usecs),
        .advanced      (advanced),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    usec_timebase_checker timebase_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .counter_value   (counter_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .time_usecs      (time_usecs),
        .advanced        (advanced),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pending         (pending),
        .mismatches      (mismatches),
        .results_checked (results_checked)
    );

    // Free-running clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Stall results at random, or hold off for a counted stretch on request
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Abort a run that hangs
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Offer one reading after a random gap and hold it until accepted
    task automatic offer_reading(input logic [COUNT_W-1:0] reading);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        counter_value <= reading;
        do @(posedge clk); while (in_stall);
        readings_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB write transaction: setup cycle, then access cycle
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TICKS_PER_USEC)
            ticks_now = data[TICKS_W-1:0];
        tick_writes++;
    endtask

    // Mostly a counter counting down by random amounts, sometimes a wild reading
    function automatic logic [COUNT_W-1:0] next_reading();
        logic [COUNT_W-1:0] step;
        int unsigned        span;
        span = (ticks_now == '0) ? 100 : ticks_now;
        if ($urandom_range(99) < 15)
            cursor = $urandom();
        else
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: step = $urandom_range(span * 3);
                4, 5:       step = $urandom_range(200000);
                6, 7:       step = span * $urandom_range(1, 4) - $urandom_range(1);
                8:          step = $urandom();
                default:    step = '0;
            endcase
            cursor = cursor - step;
        end
        return cursor;
    endfunction

    initial
    begin : stimulus
        int                    tick_plan [NUM_SEGS] = '{1, 1023, 100, RANDOM_TICKS,
                                                        7, RANDOM_TICKS, 0, 1023,
                                                        RANDOM_TICKS, 1, 50, RANDOM_TICKS};
        logic [APB_DATA_W-1:0] setting;
        int                    seg;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First reading latches, then boundaries at the reset rate and a wrap
        offer_reading(32'hFFFF_FFFF);
        offer_reading(32'hFFFF_FFFF);
        offer_reading(32'hFFFF_FF9C);
        offer_reading(32'hFFFF_FF9B);
        offer_reading(32'h0000_0000);
        offer_reading(32'hFFFF_FF00);

        // One tick per microsecond: largest differences
        apb_write(ADDR_TICKS_PER_USEC, 32'd1);
        offer_reading(32'h0000_0000);
        offer_reading(32'h0000_0000);
        offer_reading(32'h8000_0000);
        offer_reading(32'h7FFF_FFFF);
        offer_reading(32'h8000_0000);

        // Zero ticks per microsecond holds the total and the reference
        apb_write(ADDR_TICKS_PER_USEC, 32'd0);
        offer_reading(32'h1234_5678);
        offer_reading(32'h0000_0000);

        // Largest divisor, one tick short and exactly one microsecond
        apb_write(ADDR_TICKS_PER_USEC, 32'd1023);
        offer_reading(32'h0000_0000);
        offer_reading(32'hFFFF_FC02);
        offer_reading(32'hFFFF_FC01);

        // A write past the register list leaves the divisor alone
        apb_write(ADDR_UNMAPPED, 32'd5);
        offer_reading(32'hFFFF_F802);

        // Upper data bits are dropped by the register
        apb_write(ADDR_TICKS_PER_USEC, 32'hFFFF_FC05);
        offer_reading(32'hFFFF_F7FD);
        offer_reading(32'h5555_5555);
        offer_reading(32'hAAAA_AAAA);
        cursor = 32'hAAAA_AAAA;

        // Random readings over three idle profiles and several tick settings
        for (int pass = 0; pass < 3; pass++)
        begin
            case (pass)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 72;
                end
                1:
                begin
                    send_idle_pct = 72;
                    recv_idle_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int s = 0; s < SEGS_PER_PASS; s++)
            begin
                seg = pass * SEGS_PER_PASS + s;
                if (tick_plan[seg] == RANDOM_TICKS)
                    setting = ($urandom() & ~32'h3FF) | $urandom_range(1, 1023);
                else
                    setting = tick_plan[seg];
                apb_write(ADDR_TICKS_PER_USEC, setting);
                // Back up the result path while readings keep coming
                if (seg == 1)
                    hold_left = HOLD_CYCLES;
                for (int k = 0; k < SEG_ITEMS; k++)
                    offer_reading(next_reading());
            end
        end

        settle();

        $display("covered %0d counter readings, %0d results checked, %0d register writes",
                 readings_sent, results_checked, tick_writes);
        $display("idle mixes on both channels, divisors 0 to 1023, one %0d-cycle result hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
